// ===== rtl/core/hsp_pkg.sv =====
// Shared types and constants for the HTTP status line parser.
// No dependencies; imported by hsp_parse, http_status_line_parser_top and tb.
package hsp_pkg;

   localparam int LineBytesDefault = 1024;
   localparam int OffWidth         = 10;
   localparam int CodeWidth        = 10;

   typedef enum logic [3:0] {
      PH_H            = 4'd0,
      PH_T1           = 4'd1,
      PH_T2           = 4'd2,
      PH_P            = 4'd3,
      PH_SLASH        = 4'd4,
      PH_MAJOR_FIRST  = 4'd5,
      PH_MAJOR        = 4'd6,
      PH_MINOR_FIRST  = 4'd7,
      PH_MINOR        = 4'd8,
      PH_STATUS       = 4'd9,
      PH_AFTER_STATUS = 4'd10,
      PH_TEXT         = 4'd11,
      PH_ALMOST       = 4'd12
   } phase_type;

   typedef enum logic [1:0] {
      FIN_NONE = 2'd0,
      FIN_DONE = 2'd1,
      FIN_BAD  = 2'd2
   } fin_type;

   typedef struct packed {
      phase_type             phase;
      logic [CodeWidth-1:0]  code;
      logic [1:0]            count;
      logic [OffWidth-1:0]   offset;
      logic [OffWidth-1:0]   start_off;
      logic [OffWidth-1:0]   end_off;
      fin_type               fin;
   } parse_state_type;

   localparam parse_state_type StateClear = '{
      phase:     PH_H,
      code:      '0,
      count:     '0,
      offset:    '0,
      start_off: '0,
      end_off:   '0,
      fin:       FIN_NONE
   };

   localparam logic [7:0] CharH     = 8'h48;
   localparam logic [7:0] CharT     = 8'h54;
   localparam logic [7:0] CharP     = 8'h50;
   localparam logic [7:0] CharSlash = 8'h2F;
   localparam logic [7:0] CharDot   = 8'h2E;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharOne   = 8'h31;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;

   localparam logic [1:0] DigitsFull = 2'd3;

endpackage

// ===== rtl/core/hsp_parse.sv =====
// Next-state logic of the status line parser: one byte against the current state.
// Depends on hsp_pkg.
module hsp_parse #(
   parameter int OFF_LIMIT = 1023
) (
   input  hsp_pkg::parse_state_type cur_state,
   input  logic [7:0]               byte_value,
   input  logic                     line_start,
   output hsp_pkg::parse_state_type nxt_state
);
   import hsp_pkg::*;

   localparam logic [OffWidth-1:0] OffLimit = OffWidth'(OFF_LIMIT);

   parse_state_type base;
   logic            is_digit;
   logic [OffWidth-1:0] pos;

   always_comb begin
      base     = line_start ? StateClear : cur_state;
      is_digit = (byte_value >= CharZero) && (byte_value <= CharNine);
      pos      = base.offset;
   end

   always_comb begin
      parse_state_type nxt;
      logic bad;
      nxt = base;
      bad = 1'b0;
      if (base.fin == FIN_NONE) begin
         if (base.offset < OffLimit) begin
            nxt.offset = base.offset + OffWidth'(1);
         end
         unique case (base.phase)
            PH_H: begin
               if (byte_value == CharH) nxt.phase = PH_T1; else bad = 1'b1;
            end
            PH_T1: begin
               if (byte_value == CharT) nxt.phase = PH_T2; else bad = 1'b1;
            end
            PH_T2: begin
               if (byte_value == CharT) nxt.phase = PH_P; else bad = 1'b1;
            end
            PH_P: begin
               if (byte_value == CharP) nxt.phase = PH_SLASH; else bad = 1'b1;
            end
            PH_SLASH: begin
               if (byte_value == CharSlash) nxt.phase = PH_MAJOR_FIRST; else bad = 1'b1;
            end
            PH_MAJOR_FIRST: begin
               if (byte_value >= CharOne && byte_value <= CharNine) begin
                  nxt.phase = PH_MAJOR;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_MAJOR: begin
               if (byte_value == CharDot) nxt.phase = PH_MINOR_FIRST;
               else if (!is_digit) bad = 1'b1;
            end
            PH_MINOR_FIRST: begin
               if (is_digit) nxt.phase = PH_MINOR; else bad = 1'b1;
            end
            PH_MINOR: begin
               if (byte_value == CharSpace) nxt.phase = PH_STATUS;
               else if (!is_digit) bad = 1'b1;
            end
            PH_STATUS: begin
               // skip spaces before and among the digits
               if (byte_value != CharSpace) begin
                  if (!is_digit) begin
                     bad = 1'b1;
                  end else begin
                     if (base.count == 2'd0) nxt.start_off = pos;
                     // code * 10 + digit, wrapped to the code width
                     nxt.code = {base.code[CodeWidth-4:0], 3'b000}
                              + {base.code[CodeWidth-2:0], 1'b0}
                              + {{(CodeWidth-4){1'b0}}, byte_value[3:0]};
                     nxt.count = base.count + 2'd1;
                     if (nxt.count == DigitsFull) nxt.phase = PH_AFTER_STATUS;
                  end
               end
            end
            PH_AFTER_STATUS: begin
               if (byte_value == CharSpace || byte_value == CharDot) begin
                  nxt.phase = PH_TEXT;
               end else if (byte_value == CharCr) begin
                  nxt.end_off = pos;
                  nxt.phase   = PH_ALMOST;
               end else if (byte_value == CharLf) begin
                  nxt.end_off = pos;
                  nxt.fin     = FIN_DONE;
               end else begin
                  bad = 1'b1;
               end
            end
            PH_TEXT: begin
               if (byte_value == CharCr) begin
                  nxt.end_off = pos;
                  nxt.phase   = PH_ALMOST;
               end else if (byte_value == CharLf) begin
                  nxt.end_off = pos;
                  nxt.fin     = FIN_DONE;
               end
            end
            PH_ALMOST: begin
               if (byte_value == CharLf) nxt.fin = FIN_DONE; else bad = 1'b1;
            end
            default: begin
               bad = 1'b1;
            end
         endcase
         if (bad) nxt.fin = FIN_BAD;
      end
      nxt_state = nxt;
   end

endmodule

// ===== rtl/core/http_status_line_parser_top.sv =====
// Top level of the HTTP status line parser: state and result registers.
// Depends on hsp_pkg and hsp_parse.
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_ready   byte_value, line_start
//   rsp_     out        rsp_valid / rsp_ready   outcome, status_code, code_valid,
//                                               code_start, line_end
//
// One request per cycle while req_ready is high; each yields its response in the
// next cycle from the result register. The parser state register closes the only
// loop, one byte deep. req_ready drops only while a response is held and rsp_ready
// is low. Reset clears the parser to expect 'H' and empties the result register.
module http_status_line_parser_top #(
   parameter int LINE_BYTES = hsp_pkg::LineBytesDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_byte_value,
   input  logic                          req_line_start,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_outcome,
   output logic [hsp_pkg::CodeWidth-1:0] rsp_status_code,
   output logic                          rsp_code_valid,
   output logic [hsp_pkg::OffWidth-1:0]  rsp_code_start,
   output logic [hsp_pkg::OffWidth-1:0]  rsp_line_end
);
   import hsp_pkg::*;

   localparam int OffLimit = (LINE_BYTES - 1 > 1023) ? 1023 : LINE_BYTES - 1;

   parse_state_type state_ff, state_in;
   logic            rsp_valid_ff;
   logic [1:0]      outcome_ff;
   logic [CodeWidth-1:0] code_ff;
   logic            code_valid_ff;
   logic [OffWidth-1:0]  code_start_ff, line_end_ff;
   logic            accept;

   hsp_parse #(
      .OFF_LIMIT (OffLimit)
   ) u_parse (
      .cur_state  (state_ff),
      .byte_value (req_byte_value),
      .line_start (req_line_start),
      .nxt_state  (state_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateClear;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, loaded with each request
   always_ff @(posedge clock) begin
      if (accept) begin
         outcome_ff    <= state_in.fin;
         code_ff       <= state_in.code;
         code_valid_ff <= (state_in.count == DigitsFull);
         code_start_ff <= state_in.start_off;
         line_end_ff   <= state_in.end_off;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = outcome_ff;
   assign rsp_status_code = code_ff;
   assign rsp_code_valid  = code_valid_ff;
   assign rsp_code_start  = code_start_ff;
   assign rsp_line_end    = line_end_ff;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for http_status_line_parser_top: byte requests in, one
// parse response out per byte, checked against a byte-level model of the parser.
// Depends on hsp_pkg and the parser RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsp_pkg::*;

   localparam int LineBytes  = LineBytesDefault;
   localparam int OffLimit   = (LineBytes - 1 > 1023) ? 1023 : LineBytes - 1;
   localparam int CycleLimit = 200000;
   localparam int RandomBytes = 550;

   typedef struct {
      fin_type               outcome;
      logic [CodeWidth-1:0]  code;
      logic                  code_ok;
      logic [OffWidth-1:0]   code_at;
      logic [OffWidth-1:0]   end_at;
   } status_result_type;

   typedef struct {
      logic [7:0] data;
      logic       first;
   } stim_byte_type;

   class status_line_scoreboard;
      int unsigned       off_limit;
      parse_state_type   st;
      status_result_type parse_results_q[$];
      int                errors;

      function new(int unsigned limit);
         off_limit = limit;
         st = StateClear;
         errors = 0;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= CharZero && c <= CharNine;
      endfunction

      // Advance the parser state by one byte and queue the response it implies.
      function void note_byte(logic [7:0] c, logic first);
         logic [OffWidth-1:0] pos;
         bit                  bad;
         status_result_type   r;
         if (first) st = StateClear;
         if (st.fin == FIN_NONE) begin
            pos = st.offset;
            bad = 1'b0;
            if (st.offset < off_limit) st.offset = st.offset + 1'b1;
            case (st.phase)
               PH_H:     if (c == CharH) st.phase = PH_T1; else bad = 1'b1;
               PH_T1:    if (c == CharT) st.phase = PH_T2; else bad = 1'b1;
               PH_T2:    if (c == CharT) st.phase = PH_P; else bad = 1'b1;
               PH_P:     if (c == CharP) st.phase = PH_SLASH; else bad = 1'b1;
               PH_SLASH: if (c == CharSlash) st.phase = PH_MAJOR_FIRST; else bad = 1'b1;
               PH_MAJOR_FIRST: begin
                  if (c >= CharOne && c <= CharNine) st.phase = PH_MAJOR;
                  else bad = 1'b1;
               end
               PH_MAJOR: begin
                  if (c == CharDot) st.phase = PH_MINOR_FIRST;
                  else if (!is_digit(c)) bad = 1'b1;
               end
               PH_MINOR_FIRST: if (is_digit(c)) st.phase = PH_MINOR; else bad = 1'b1;
               PH_MINOR: begin
                  if (c == CharSpace) st.phase = PH_STATUS;
                  else if (!is_digit(c)) bad = 1'b1;
               end
               PH_STATUS: begin
                  // spaces are skipped both before and between the digits
                  if (c != CharSpace) begin
                     if (!is_digit(c)) begin
                        bad = 1'b1;
                     end else begin
                        if (st.count == 2'd0) st.start_off = pos;
                        st.code = CodeWidth'(st.code * 10 + (c - CharZero));
                        st.count = st.count + 2'd1;
                        if (st.count == DigitsFull) st.phase = PH_AFTER_STATUS;
                     end
                  end
               end
               PH_AFTER_STATUS: begin
                  if (c == CharSpace || c == CharDot) begin
                     st.phase = PH_TEXT;
                  end else if (c == CharCr) begin
                     st.end_off = pos;
                     st.phase = PH_ALMOST;
                  end else if (c == CharLf) begin
                     st.end_off = pos;
                     st.fin = FIN_DONE;
                  end else begin
                     bad = 1'b1;
                  end
               end
               PH_TEXT: begin
                  if (c == CharCr) begin
                     st.end_off = pos;
                     st.phase = PH_ALMOST;
                  end else if (c == CharLf) begin
                     st.end_off = pos;
                     st.fin = FIN_DONE;
                  end
               end
               PH_ALMOST: if (c == CharLf) st.fin = FIN_DONE; else bad = 1'b1;
               default: bad = 1'b1;
            endcase
            if (bad) st.fin = FIN_BAD;
         end
         r.outcome = st.fin;
         r.code    = st.code;
         r.code_ok = (st.count == DigitsFull);
         r.code_at = st.start_off;
         r.end_at  = st.end_off;
         parse_results_q.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR at %0t: %s", $time, msg);
      endtask

      task check_result(status_result_type got);
         status_result_type want;
         if (parse_results_q.size() == 0) begin
            report("response with no request pending");
            return;
         end
         want = parse_results_q.pop_front();
         if (got.outcome !== want.outcome)
            report($sformatf("outcome got %0d want %0d", got.outcome, want.outcome));
         if (got.code !== want.code)
            report($sformatf("status_code got %0d want %0d", got.code, want.code));
         if (got.code_ok !== want.code_ok)
            report($sformatf("code_valid got %0b want %0b", got.code_ok, want.code_ok));
         if (got.code_at !== want.code_at)
            report($sformatf("code_start got %0d want %0d", got.code_at, want.code_at));
         if (got.end_at !== want.end_at)
            report($sformatf("line_end got %0d want %0d", got.end_at, want.end_at));
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_byte_value;
   logic                 req_line_start;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [1:0]           rsp_outcome;
   logic [CodeWidth-1:0] rsp_status_code;
   logic                 rsp_code_valid;
   logic [OffWidth-1:0]  rsp_code_start;
   logic [OffWidth-1:0]  rsp_line_end;

   status_line_scoreboard sb;
   status_result_type     rsp_seen;
   stim_byte_type         line_q[$];
   bit                    calm = 1'b0;
   int                    bytes_sent = 0;
   int                    cycle_count = 0;

   http_status_line_parser_top #(.LINE_BYTES(LineBytes)) uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("http_status_line_parser_top test failed");
         $finish;
      end
   end

   // Check responses before noting requests taken at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen.outcome = fin_type'(rsp_outcome);
            rsp_seen.code    = rsp_status_code;
            rsp_seen.code_ok = rsp_code_valid;
            rsp_seen.code_at = rsp_code_start;
            rsp_seen.end_at  = rsp_line_end;
            sb.check_result(rsp_seen);
         end
         if (req_valid && req_ready) sb.note_byte(req_byte_value, req_line_start);
      end
   end

   function automatic void add_byte(logic [7:0] b, logic first);
      stim_byte_type s;
      s.data = b;
      s.first = first;
      line_q.push_back(s);
   endfunction

   function automatic void add_text(string t, logic first);
      for (int i = 0; i < t.len(); i++) add_byte(t[i], (i == 0) ? first : 1'b0);
   endfunction

   function automatic void add_digit();
      add_byte(8'(CharZero + $urandom_range(0, 9)), 1'b0);
   endfunction

   // A negative text_len ends the line right after the code.
   function automatic void add_good_line(int text_len, logic first);
      logic [7:0] b;
      add_text("HTTP/", first);
      add_byte(8'(CharZero + $urandom_range(1, 9)), 1'b0);
      repeat ($urandom_range(0, 2)) add_digit();
      add_byte(CharDot, 1'b0);
      repeat ($urandom_range(1, 2)) add_digit();
      add_byte(CharSpace, 1'b0);
      repeat ($urandom_range(0, 2)) add_byte(CharSpace, 1'b0);
      repeat (3) begin
         if ($urandom_range(0, 7) == 0) add_byte(CharSpace, 1'b0);
         add_digit();
      end
      if (text_len >= 0) begin
         add_byte($urandom_range(0, 1) ? CharSpace : CharDot, 1'b0);
         repeat (text_len) begin
            b = 8'($urandom_range(0, 255));
            if (b == CharCr || b == CharLf) b = CharSpace;
            add_byte(b, 1'b0);
         end
      end
      if ($urandom_range(0, 1)) add_byte(CharCr, 1'b0);
      add_byte(CharLf, 1'b0);
   endfunction

   // Corrupt one byte or cut the line short.
   function automatic void break_line();
      int idx;
      idx = $urandom_range(0, line_q.size() - 1);
      if ($urandom_range(0, 1)) line_q[idx].data = 8'($urandom_range(0, 255));
      else while (line_q.size() > idx + 1) line_q.pop_back();
   endfunction

   task automatic send_byte(logic [7:0] b, logic first);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_byte_value <= b;
      req_line_start <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_byte(line_q[i].data, line_q[i].first);
      line_q.delete();
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.parse_results_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         if (calm) begin
            @(posedge clock);
         end else begin
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 10))
               @(posedge clock);
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   initial begin
      int kind;
      int n;
      int random_items;
      bit long_done;
      bit paused;
      sb = new(OffLimit);
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_byte_value <= 8'h00;
      req_line_start <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // No start mark after reset, spaces among the digits, bare LF ending.
      add_text("HTTP/1.0 4 04\n", 1'b0);
      // Ignored after completion.
      add_text("z", 1'b0);
      // Bad first byte, then a byte ignored after the error.
      add_byte(8'hFF, 1'b1);
      add_byte(8'h00, 1'b0);
      // Major version may not begin with zero.
      add_text("HTTP/0", 1'b1);
      send_line();

      random_items = 0;
      long_done = 1'b0;
      paused = 1'b0;
      while (random_items < RandomBytes) begin
         if (!long_done && random_items >= 150) begin
            // drive the offsets into saturation
            add_good_line(1100, 1'b1);
            send_line();
            long_done = 1'b1;
         end
         if (!paused && random_items >= 275) begin
            wait_for_responses();
            paused = 1'b1;
         end
         if (random_items >= 440) calm = 1'b1;
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            add_good_line($urandom_range(0, 1) ? -1 : $urandom_range(0, 12),
                          $urandom_range(0, 15) != 0);
            repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)), 1'b0);
         end else if (kind <= 8) begin
            add_good_line($urandom_range(0, 1) ? -1 : $urandom_range(0, 12), 1'b1);
            break_line();
         end else begin
            repeat ($urandom_range(1, 6))
               add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
         end
         n = line_q.size();
         send_line();
         random_items += n;
      end

      wait_for_responses();
      repeat (4) @(posedge clock);
      if (sb.parse_results_q.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.parse_results_q.size()));
      if (sb.errors == 0) begin
         $display("http_status_line_parser_top test passed");
      end else begin
         $display("http_status_line_parser_top test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/hsp_pkg.sv
rtl/core/hsp_parse.sv
rtl/core/http_status_line_parser_top.sv
tb/tb.sv
